// ===== design/aal_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive admission limiter package
// Shared types, register indexes, reset values and thresholds for the
// adaptive admission limiter.
// ----------------------------------------------------------------------------
package aal_pkg;

  localparam int unsigned RecoveryRatioQ8Dflt = 205;
  localparam int unsigned CooldownSamplesDflt = 4;

  localparam int unsigned LimitW   = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned RatioW   = 11;
  localparam int unsigned RunW     = 8;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMinLimit       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLimit       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgQueueCapacity  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTargetLatency  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCritLatency    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCacheUsageLim  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMemoryUsageLim = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWaitingLimit   = 3'd7;

  localparam logic [LimitW-1:0] MinLimitRst       = 12'd1;
  localparam logic [LimitW-1:0] MaxLimitRst       = 12'd64;
  localparam logic [CountW-1:0] QueueCapacityRst  = 16'd256;
  localparam logic [CountW-1:0] TargetLatencyRst  = 16'd500;
  localparam logic [CountW-1:0] CritLatencyRst    = 16'd2000;
  localparam logic [RatioW-1:0] CacheUsageLimRst  = 11'd922;
  localparam logic [RatioW-1:0] MemoryUsageLimRst = 11'd922;
  localparam logic [CountW-1:0] WaitingLimitRst   = 16'd64;

  localparam logic [RatioW-1:0] CritUsageQ10 = 11'd1004;
  localparam logic [RatioW-1:0] CritFailQ10  = 11'd103;
  localparam logic [RatioW-1:0] RecovFailQ10 = 11'd11;

  typedef enum logic [1:0] {
    DecAdmit  = 2'd0,
    DecQueue  = 2'd1,
    DecReject = 2'd2
  } decision_e;

  typedef struct packed {
    logic [CountW-1:0] latency_ms;
    logic [RatioW-1:0] cache_usage;
    logic [RatioW-1:0] memory_usage;
    logic [CountW-1:0] waiting_count;
    logic [RatioW-1:0] failure_rate;
    logic [CountW-1:0] inflight_now;
    logic [CountW-1:0] queued_now;
  } sample_t;

  typedef struct packed {
    logic [1:0]        decision;
    logic [LimitW-1:0] limit_now;
    logic              overloaded;
    logic              critical;
  } result_t;

  typedef struct packed {
    logic [LimitW-1:0] min_limit;
    logic [LimitW-1:0] max_limit;
    logic [CountW-1:0] queue_capacity;
    logic [CountW-1:0] target_latency_ms;
    logic [CountW-1:0] critical_latency_ms;
    logic [RatioW-1:0] cache_usage_limit;
    logic [RatioW-1:0] memory_usage_limit;
    logic [CountW-1:0] waiting_limit;
  } cfg_t;

  typedef struct packed {
    logic soft_ovl;
    logic crit;
    logic recov;
  } flags_t;

endpackage

// ===== design/aal_classify.sv =====
// ----------------------------------------------------------------------------
// Sample classifier
// Compares one registered metrics sample against the thresholds and flags
// soft overload, critical overload and recovery.
// ----------------------------------------------------------------------------
module aal_classify #(
  parameter int unsigned RECOVERY_RATIO_Q8 = aal_pkg::RecoveryRatioQ8Dflt
) (
  input  aal_pkg::sample_t sample_i,
  input  aal_pkg::cfg_t    cfg_i,
  output aal_pkg::flags_t  flags_o
);
  import aal_pkg::*;

  localparam logic [ScaleW-1:0] Ratio = ScaleW'(RECOVERY_RATIO_Q8);

  logic [ScaleW-1:0] lat_s, cache_s, mem_s, wait_s;
  logic [ScaleW-1:0] lat_t, cache_t, mem_t, wait_t;

  // Recovery tests x < t * ratio / 256 exactly as x * 256 < t * ratio.
  assign lat_s   = {sample_i.latency_ms, 8'h00};
  assign cache_s = ScaleW'({sample_i.cache_usage, 8'h00});
  assign mem_s   = ScaleW'({sample_i.memory_usage, 8'h00});
  assign wait_s  = {sample_i.waiting_count, 8'h00};

  assign lat_t   = ScaleW'(cfg_i.target_latency_ms) * Ratio;
  assign cache_t = ScaleW'(cfg_i.cache_usage_limit) * Ratio;
  assign mem_t   = ScaleW'(cfg_i.memory_usage_limit) * Ratio;
  assign wait_t  = ScaleW'(cfg_i.waiting_limit) * Ratio;

  always_comb begin
    flags_o.soft_ovl = (sample_i.latency_ms >= cfg_i.target_latency_ms) ||
                       (sample_i.cache_usage >= cfg_i.cache_usage_limit) ||
                       (sample_i.memory_usage >= cfg_i.memory_usage_limit) ||
                       (sample_i.waiting_count >= cfg_i.waiting_limit);
    flags_o.crit  = (sample_i.latency_ms >= cfg_i.critical_latency_ms) ||
                    (sample_i.cache_usage >= CritUsageQ10) ||
                    (sample_i.memory_usage >= CritUsageQ10) ||
                    (sample_i.failure_rate >= CritFailQ10);
    flags_o.recov = (lat_s < lat_t) && (cache_s < cache_t) && (mem_s < mem_t) &&
                    (wait_s < wait_t) && (sample_i.failure_rate < RecovFailQ10);
  end

endmodule

// ===== design/aal_adapt.sv =====
// ----------------------------------------------------------------------------
// Limit adaptation
// Holds the concurrency limit, the cooldown counter and the recovery run,
// and updates them once per sample from the overload and recovery flags.
// ----------------------------------------------------------------------------
module aal_adapt #(
  parameter int unsigned COOLDOWN_LEN = aal_pkg::CooldownSamplesDflt
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  aal_pkg::flags_t            flags_i,
  input  logic [aal_pkg::LimitW-1:0] min_limit_i,
  input  logic [aal_pkg::LimitW-1:0] max_limit_i,
  output logic [aal_pkg::LimitW-1:0] limit_o
);
  import aal_pkg::*;

  localparam logic [RunW-1:0] Cooldown = RunW'(COOLDOWN_LEN);

  logic [LimitW-1:0] limit_q, limit_d;
  logic [RunW-1:0]   cool_q, cool_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [LimitW-1:0] half, dec;
  logic [LimitW:0]   inc;
  logic [RunW-1:0]   run_inc;

  always_comb begin
    half    = limit_q >> 1;
    dec     = (limit_q != '0) ? limit_q - 1'b1 : '0;
    inc     = {1'b0, limit_q} + 1'b1;
    run_inc = run_q + 1'b1;
    limit_d = limit_q;
    cool_d  = cool_q;
    run_d   = run_q;
    if (flags_i.crit) begin
      limit_d = (half > min_limit_i) ? half : min_limit_i;
      cool_d  = Cooldown;
      run_d   = '0;
    end else if (flags_i.soft_ovl) begin
      limit_d = (dec > min_limit_i) ? dec : min_limit_i;
      cool_d  = Cooldown;
      run_d   = '0;
    end else if (cool_q != '0) begin
      cool_d = cool_q - 1'b1;
    end else if (!flags_i.recov) begin
      run_d = '0;
    end else if (run_inc >= Cooldown) begin
      limit_d = (inc < {1'b0, max_limit_i}) ? inc[LimitW-1:0] : max_limit_i;
      run_d   = '0;
    end else begin
      run_d = run_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxLimitRst;
      cool_q  <= '0;
      run_q   <= '0;
    end else if (en_i) begin
      limit_q <= limit_d;
      cool_q  <= cool_d;
      run_q   <= run_d;
    end
  end

  assign limit_o = limit_d;

endmodule

// ===== design/adaptive_admission_limiter.sv =====
// ----------------------------------------------------------------------------
// Adaptive admission limiter
// An accepted sample beat is registered in the sample register, then its result in the result register.
// Throughput is one sample per cycle while out_stall_i is low, set by the single-pass limit update.
// Reset is asynchronous and active low; it restores the register defaults,
// sets the limit to the maximum-limit default and clears the counters.
// ----------------------------------------------------------------------------
module adaptive_admission_limiter #(
  parameter int unsigned RECOVERY_RATIO_Q8 = aal_pkg::RecoveryRatioQ8Dflt,
  parameter int unsigned COOLDOWN_LEN      = aal_pkg::CooldownSamplesDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  aal_pkg::sample_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output aal_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [aal_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [aal_pkg::CfgDataW-1:0] cfg_data_i
);
  import aal_pkg::*;

  cfg_t              cfg_q;
  sample_t           smp_q;
  logic              smp_valid_q;
  result_t           res_q, res_d;
  logic              res_valid_q;
  logic              advance, accept;
  flags_t            flags;
  logic [LimitW-1:0] limit_new;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_limit           <= MinLimitRst;
      cfg_q.max_limit           <= MaxLimitRst;
      cfg_q.queue_capacity      <= QueueCapacityRst;
      cfg_q.target_latency_ms   <= TargetLatencyRst;
      cfg_q.critical_latency_ms <= CritLatencyRst;
      cfg_q.cache_usage_limit   <= CacheUsageLimRst;
      cfg_q.memory_usage_limit  <= MemoryUsageLimRst;
      cfg_q.waiting_limit       <= WaitingLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMinLimit:       cfg_q.min_limit           <= cfg_data_i[LimitW-1:0];
        CfgMaxLimit:       cfg_q.max_limit           <= cfg_data_i[LimitW-1:0];
        CfgQueueCapacity:  cfg_q.queue_capacity      <= cfg_data_i;
        CfgTargetLatency:  cfg_q.target_latency_ms   <= cfg_data_i;
        CfgCritLatency:    cfg_q.critical_latency_ms <= cfg_data_i;
        CfgCacheUsageLim:  cfg_q.cache_usage_limit   <= cfg_data_i[RatioW-1:0];
        CfgMemoryUsageLim: cfg_q.memory_usage_limit  <= cfg_data_i[RatioW-1:0];
        CfgWaitingLimit:   cfg_q.waiting_limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A sample moves on whenever the result register is empty or being drained.
  assign advance    = smp_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = smp_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (accept) begin
      smp_valid_q <= 1'b1;
    end else if (advance) begin
      smp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= in_data_i;
    end
  end

  aal_classify #(
    .RECOVERY_RATIO_Q8(RECOVERY_RATIO_Q8)
  ) u_classify (
    .sample_i(smp_q),
    .cfg_i   (cfg_q),
    .flags_o (flags)
  );

  aal_adapt #(
    .COOLDOWN_LEN(COOLDOWN_LEN)
  ) u_adapt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .flags_i    (flags),
    .min_limit_i(cfg_q.min_limit),
    .max_limit_i(cfg_q.max_limit),
    .limit_o    (limit_new)
  );

  always_comb begin
    if (flags.crit || (smp_q.queued_now >= cfg_q.queue_capacity)) begin
      res_d.decision = DecReject;
    end else if (flags.soft_ovl || (smp_q.inflight_now >= CountW'(limit_new))) begin
      res_d.decision = DecQueue;
    end else begin
      res_d.decision = DecAdmit;
    end
    res_d.limit_now  = limit_new;
    res_d.overloaded = flags.soft_ovl || flags.crit;
    res_d.critical   = flags.crit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
